FILE: sv/qalu_pkg.sv
// Shared types, constants and helpers of the quaternion ALU.
`timescale 1ns / 1ps
package qalu_pkg;

  // Pipeline depths of the root and divide sections
  localparam int unsigned SqrtStages = 32;
  localparam int unsigned DivStages  = 48;

  // Operation codes
  localparam logic [3:0] OpAdd   = 4'd0;
  localparam logic [3:0] OpSub   = 4'd1;
  localparam logic [3:0] OpMul   = 4'd2;
  localparam logic [3:0] OpScale = 4'd3;
  localparam logic [3:0] OpDiv   = 4'd4;
  localparam logic [3:0] OpConj  = 4'd5;
  localparam logic [3:0] OpInv   = 4'd6;
  localparam logic [3:0] OpNorm  = 4'd7;
  localparam logic [3:0] OpLen   = 4'd8;
  localparam logic [3:0] OpSqLen = 4'd9;

  // Register index of the epsilon threshold
  localparam logic [0:0] RegEps = 1'b0;

  localparam logic [15:0] EpsReset = 16'd1;
  localparam logic [47:0] OneQ     = 48'd65536;
  localparam logic [30:0] MagMax   = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] scalar_val;
  } req_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic [30:0]        magnitude;
    logic               saturated;
    logic               degenerate;
  } rsp_t;

  // Item state carried down the pipeline
  typedef struct packed {
    logic [3:0]        op;
    logic [3:0][31:0]  pre;      // final value for ops that skip the divider
    logic [3:0]        neg;      // dividend sign per lane
    logic [3:0][31:0]  absx;     // dividend magnitude per lane
    logic              use_div;
    logic              div_norm; // divisor comes from the square root
    logic [47:0]       dvsr;
    logic [30:0]       mag;
    logic              sat;
    logic              deg;
  } pipe_t;

  // Clip to signed 32 bits; bit 32 of the result flags a clip
  function automatic logic [32:0] sat32(input logic signed [50:0] v);
    logic [32:0] r;
    if (v > 51'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -51'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

FILE: sv/qalu_front.sv
// Front end: operand products, then sums, norm and per-op selection.
`timescale 1ns / 1ps
module qalu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qalu_pkg::req_t req_i,
  input  logic [15:0]    eps_i,
  output logic           valid_o,
  output qalu_pkg::pipe_t pipe_o,
  output logic [63:0]    sq_o
);
  import qalu_pkg::*;

  logic signed [31:0] a_in [4];
  logic signed [31:0] b_in [4];

  logic               v1_q;
  req_t               req1_q;
  logic signed [63:0] pab_d [4][4];
  logic signed [63:0] pab_q [4][4];
  logic signed [63:0] pas_d [4];
  logic signed [63:0] pas_q [4];
  logic [63:0]        paa_d [4];
  logic [63:0]        paa_q [4];

  assign a_in[0] = req_i.a_x;
  assign a_in[1] = req_i.a_y;
  assign a_in[2] = req_i.a_z;
  assign a_in[3] = req_i.a_w;
  assign b_in[0] = req_i.b_x;
  assign b_in[1] = req_i.b_y;
  assign b_in[2] = req_i.b_z;
  assign b_in[3] = req_i.b_w;

  // Stage 1: all products in parallel
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pab_d[i][j] = a_in[i] * b_in[j];
      end
      pas_d[i] = a_in[i] * req_i.scalar_val;
      paa_d[i] = 64'(a_in[i] * a_in[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req1_q <= req_i;
      pab_q  <= pab_d;
      pas_q  <= pas_d;
      paa_q  <= paa_d;
    end
  end

  // Stage 2: sums, norm, saturation and divider setup
  logic signed [31:0] a2 [4];
  logic signed [31:0] b2 [4];
  logic signed [66:0] hs [4];
  logic [64:0]        ssum;
  logic [63:0]        s_clamp;
  logic [47:0]        n2;
  logic signed [50:0] v51 [4];
  logic signed [32:0] xv [4];
  logic signed [32:0] xneg;
  logic [32:0]        sr;
  pipe_t              pipe_d;
  logic               v2_q;
  pipe_t              pipe_q;
  logic [63:0]        sq_q;

  assign a2[0] = req1_q.a_x;
  assign a2[1] = req1_q.a_y;
  assign a2[2] = req1_q.a_z;
  assign a2[3] = req1_q.a_w;
  assign b2[0] = req1_q.b_x;
  assign b2[1] = req1_q.b_y;
  assign b2[2] = req1_q.b_z;
  assign b2[3] = req1_q.b_w;

  // Hamilton product sums, exact before the floor shift
  assign hs[0] = pab_q[3][0] + pab_q[0][3] + pab_q[2][1] - pab_q[1][2];
  assign hs[1] = pab_q[3][1] + pab_q[1][3] + pab_q[0][2] - pab_q[2][0];
  assign hs[2] = pab_q[3][2] + pab_q[2][3] + pab_q[1][0] - pab_q[0][1];
  assign hs[3] = pab_q[3][3] - pab_q[0][0] - pab_q[1][1] - pab_q[2][2];

  // Squared norm in Q32.32, clamped when all components are most negative
  assign ssum    = 65'(paa_q[0]) + 65'(paa_q[1]) + 65'(paa_q[2]) + 65'(paa_q[3]);
  assign s_clamp = ssum[64] ? {64{1'b1}} : ssum[63:0];
  assign n2      = s_clamp[63:16];

  always_comb begin
    pipe_d    = '0;
    pipe_d.op = req1_q.req_type;
    xneg      = '0;
    sr        = '0;
    for (int i = 0; i < 4; i++) begin
      v51[i] = '0;
      xv[i]  = 33'(a2[i]);
    end
    unique case (req1_q.req_type)
      OpAdd: begin
        for (int i = 0; i < 4; i++) v51[i] = 51'(a2[i]) + 51'(b2[i]);
      end
      OpSub: begin
        for (int i = 0; i < 4; i++) v51[i] = 51'(a2[i]) - 51'(b2[i]);
      end
      OpMul: begin
        for (int i = 0; i < 4; i++) v51[i] = $signed(hs[i][66:16]);
      end
      OpScale: begin
        for (int i = 0; i < 4; i++) v51[i] = 51'($signed(pas_q[i][63:16]));
      end
      OpDiv: begin
        if (req1_q.scalar_val <= $signed({17'b0, eps_i})) begin
          pipe_d.deg = 1'b1;
          for (int i = 0; i < 4; i++) v51[i] = 51'(a2[i]);
        end else begin
          pipe_d.use_div = 1'b1;
          pipe_d.dvsr    = {16'b0, req1_q.scalar_val[31:0]};
        end
      end
      OpConj: begin
        for (int i = 0; i < 3; i++) v51[i] = -51'(a2[i]);
        v51[3] = 51'(a2[3]);
      end
      OpInv: begin
        for (int i = 0; i < 3; i++) xv[i] = -33'(a2[i]);
        if (n2 <= {32'b0, eps_i}) begin
          pipe_d.deg = 1'b1;
          for (int i = 0; i < 4; i++) v51[i] = 51'(a2[i]);
        end else begin
          pipe_d.use_div = 1'b1;
          pipe_d.dvsr    = n2;
        end
      end
      OpNorm: begin
        pipe_d.use_div  = 1'b1;
        pipe_d.div_norm = 1'b1;
      end
      OpLen: begin
        // magnitude is set after the square root
      end
      OpSqLen: begin
        if (n2 > {17'b0, MagMax}) begin
          pipe_d.mag = MagMax;
          pipe_d.sat = 1'b1;
        end else begin
          pipe_d.mag = n2[30:0];
        end
      end
      default: begin
      end
    endcase

    // Clip non-divider results; split dividends into sign and magnitude
    for (int i = 0; i < 4; i++) begin
      sr            = sat32(v51[i]);
      pipe_d.pre[i] = sr[31:0];
      if (sr[32]) pipe_d.sat = 1'b1;
      xneg           = -xv[i];
      pipe_d.neg[i]  = xv[i][32];
      pipe_d.absx[i] = xv[i][32] ? xneg[31:0] : xv[i][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
      sq_q   <= s_clamp;
    end
  end

  assign valid_o = v2_q;
  assign pipe_o  = pipe_q;
  assign sq_o    = sq_q;

endmodule

FILE: sv/qalu_sqrt.sv
// Pipelined integer square root of the squared norm, one root bit per stage.
`timescale 1ns / 1ps
module qalu_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qalu_pkg::pipe_t pipe_i,
  input  logic [63:0]     sq_i,
  output logic            valid_o,
  output qalu_pkg::pipe_t pipe_o,
  output logic [31:0]     root_o
);
  import qalu_pkg::*;

  logic        vld_q [SqrtStages];
  pipe_t       pl_q  [SqrtStages];
  logic [63:0] rem_q [SqrtStages];
  logic [63:0] res_q [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);

    logic        cur_v;
    pipe_t       cur_p;
    logic [63:0] cur_rem;
    logic [63:0] cur_res;
    logic [63:0] trial;
    logic [63:0] rem_d;
    logic [63:0] res_d;

    if (k == 0) begin : g_src_in
      assign cur_v   = valid_i;
      assign cur_p   = pipe_i;
      assign cur_rem = sq_i;
      assign cur_res = '0;
    end else begin : g_src_prev
      assign cur_v   = vld_q[k-1];
      assign cur_p   = pl_q[k-1];
      assign cur_rem = rem_q[k-1];
      assign cur_res = res_q[k-1];
    end

    // One restoring root step
    always_comb begin
      trial = cur_res + Bit;
      if (cur_rem >= trial) begin
        rem_d = cur_rem - trial;
        res_d = (cur_res >> 1) + Bit;
      end else begin
        rem_d = cur_rem;
        res_d = cur_res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pl_q[k]  <= cur_p;
        rem_q[k] <= rem_d;
        res_q[k] <= res_d;
      end
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign pipe_o  = pl_q[SqrtStages-1];
  assign root_o  = res_q[SqrtStages-1][31:0];

endmodule

FILE: sv/qalu_div.sv
// Divisor select, four-lane pipelined divider and output stage.
`timescale 1ns / 1ps
module qalu_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qalu_pkg::pipe_t pipe_i,
  input  logic [31:0]     root_i,
  input  logic [15:0]     eps_i,
  output logic            valid_o,
  output qalu_pkg::rsp_t  rsp_o
);
  import qalu_pkg::*;

  // Select stage: normalize divisor and length magnitude from the root
  pipe_t m_d;
  pipe_t m_q;
  logic  m_v_q;

  always_comb begin
    m_d = pipe_i;
    if (pipe_i.div_norm) begin
      if (root_i <= {16'b0, eps_i}) begin
        m_d.deg  = 1'b1;
        m_d.dvsr = OneQ;
      end else begin
        m_d.dvsr = {16'b0, root_i};
      end
    end
    if (pipe_i.op == OpLen) begin
      if (root_i[31]) begin
        m_d.mag = MagMax;
        m_d.sat = 1'b1;
      end else begin
        m_d.mag = root_i[30:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en_i) begin
      m_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
    end
  end

  // Divide stages: one quotient bit per lane per stage
  logic             dv_q  [DivStages];
  pipe_t            dp_q  [DivStages];
  logic [3:0][47:0] rem_q [DivStages];
  logic [3:0][47:0] nq_q  [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic             cur_v;
    pipe_t            cur_p;
    logic [3:0][47:0] cur_rem;
    logic [3:0][47:0] cur_nq;
    logic [3:0][47:0] rem_d;
    logic [3:0][47:0] nq_d;
    logic [48:0]      trial [4];
    logic [48:0]      diff [4];

    if (k == 0) begin : g_src_in
      assign cur_v   = m_v_q;
      assign cur_p   = m_q;
      assign cur_rem = '0;
      always_comb begin
        for (int i = 0; i < 4; i++) cur_nq[i] = {m_q.absx[i], 16'b0};
      end
    end else begin : g_src_prev
      assign cur_v   = dv_q[k-1];
      assign cur_p   = dp_q[k-1];
      assign cur_rem = rem_q[k-1];
      assign cur_nq  = nq_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        trial[i] = {cur_rem[i], cur_nq[i][47]};
        diff[i]  = trial[i] - {1'b0, cur_p.dvsr};
        if (trial[i] >= {1'b0, cur_p.dvsr}) begin
          rem_d[i] = diff[i][47:0];
          nq_d[i]  = {cur_nq[i][46:0], 1'b1};
        end else begin
          rem_d[i] = trial[i][47:0];
          nq_d[i]  = {cur_nq[i][46:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_q[k] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dp_q[k]  <= cur_p;
        rem_q[k] <= rem_d;
        nq_q[k]  <= nq_d;
      end
    end
  end

  // Output stage: apply sign, clip, pack the result item
  pipe_t              fp;
  logic signed [50:0] qs [4];
  logic [32:0]        sr [4];
  logic [31:0]        rv [4];
  logic               sat_any;
  rsp_t               rsp_d;
  rsp_t               rsp_q;
  logic               out_v_q;

  assign fp = dp_q[DivStages-1];

  always_comb begin
    sat_any = fp.sat;
    for (int i = 0; i < 4; i++) begin
      qs[i] = $signed({3'b0, nq_q[DivStages-1][i]});
      if (fp.neg[i]) qs[i] = -qs[i];
      sr[i] = sat32(qs[i]);
      if (fp.use_div) begin
        rv[i] = sr[i][31:0];
        if (sr[i][32]) sat_any = 1'b1;
      end else begin
        rv[i] = fp.pre[i];
      end
    end
    rsp_d.r_x        = rv[0];
    rsp_d.r_y        = rv[1];
    rsp_d.r_z        = rv[2];
    rsp_d.r_w        = rv[3];
    rsp_d.magnitude  = fp.mag;
    rsp_d.saturated  = sat_any;
    rsp_d.degenerate = fp.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= dv_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = out_v_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: sv/quaternion_alu_top.sv
// Quaternion ALU top level: configuration port, pipeline wiring, checks.
`timescale 1ns / 1ps
// Streaming quaternion ALU in signed Q16.16. Each item carries an opcode, two
// quaternions and a scalar and yields exactly one result item, in order. The
// unit is fully pipelined: one item enters per cycle while the output is free.
// Each item passes 2 front-end stages for products and sums, 32 square-root
// stages, 1 divisor-select stage, 48 divide stages and 1 output register. All
// operations run the same path. When the output is not taken the whole
// pipeline holds and in_ready_o drops. The epsilon threshold sits at address 0
// of the APB port and resets to 1.
module quaternion_alu_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qalu_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qalu_pkg::rsp_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import qalu_pkg::*;

  logic [15:0] eps_q;
  logic        en;
  logic        f_v;
  pipe_t       f_p;
  logic [63:0] f_sq;
  logic        s_v;
  pipe_t       s_p;
  logic [31:0] s_root;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (psel && penable && pwrite && (paddr[2:2] == RegEps)) begin
      eps_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == RegEps) ? {16'b0, eps_q} : 32'b0;

  // Whole pipeline advances unless a finished item is held at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  qalu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_data_i),
    .eps_i   (eps_q),
    .valid_o (f_v),
    .pipe_o  (f_p),
    .sq_o    (f_sq)
  );

  qalu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .pipe_i  (f_p),
    .sq_i    (f_sq),
    .valid_o (s_v),
    .pipe_o  (s_p),
    .root_o  (s_root)
  );

  qalu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_v),
    .pipe_i  (s_p),
    .root_i  (s_root),
    .eps_i   (eps_q),
    .valid_o (out_valid_o),
    .rsp_o   (out_data_o)
  );

`ifndef ASSERT_OFF
  // Only length ops report a magnitude, and they leave the quaternion at zero
  a_mag_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.magnitude != '0) |->
      (out_data_o.r_x == '0) && (out_data_o.r_y == '0) &&
      (out_data_o.r_z == '0) && (out_data_o.r_w == '0))
    else $error("magnitude reported together with a nonzero quaternion");

  // Degenerate cases return a or a/1.0 and can never clip
  a_deg_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> !out_data_o.saturated)
    else $error("degenerate result flagged as saturated");

  // A held output item must block new items
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted while the pipeline is stalled");
`endif

endmodule

FILE: tb/tb_quaternion_alu_top.sv
// Self-checking testbench of the quaternion ALU top level.
`timescale 1ns / 1ps
module tb_quaternion_alu_top;
  import qalu_pkg::*;

  typedef logic signed [95:0] wide_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 120;   // pipeline is 84 deep
  localparam int unsigned LongHold = 400;
  localparam logic [3:0] OpSpareLo = 4'd10;
  localparam logic [3:0] OpSpareHi = 4'd15;
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  req_t in_data_i;
  rsp_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  quaternion_alu_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  req_t pending_items[$];
  rsp_t expected_rsp[$];
  logic [15:0] eps_copy;
  logic no_idle;
  int unsigned send_wait, recv_wait, n_results, n_cycles, n_errors;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Integer square root, floor
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res, bt;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Expected result of one item under threshold eps
  function automatic rsp_t quat_predict(req_t q, logic [15:0] eps);
    wide_t a[4], b[4], r[4];
    wide_t s, e, sq, n2, m, mo;
    logic [63:0] sq64;
    logic sat, deg;
    rsp_t o;
    a[0] = $signed(q.a_x); a[1] = $signed(q.a_y);
    a[2] = $signed(q.a_z); a[3] = $signed(q.a_w);
    b[0] = $signed(q.b_x); b[1] = $signed(q.b_y);
    b[2] = $signed(q.b_z); b[3] = $signed(q.b_w);
    s = $signed(q.scalar_val);
    e = $signed({80'd0, eps});
    for (int i = 0; i < 4; i++) r[i] = '0;
    mo = '0;
    sat = 1'b0;
    deg = 1'b0;
    // exact Q32.32 squared norm, clipped to 64 bits
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
    if (sq > $signed(96'hFFFF_FFFF_FFFF_FFFF)) sq = $signed(96'hFFFF_FFFF_FFFF_FFFF);
    sq64 = sq[63:0];
    case (q.req_type)
      OpAdd: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      OpSub: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      OpMul: begin
        r[0] = (a[3] * b[0] + a[0] * b[3] + a[2] * b[1] - a[1] * b[2]) >>> 16;
        r[1] = (a[3] * b[1] + a[1] * b[3] + a[0] * b[2] - a[2] * b[0]) >>> 16;
        r[2] = (a[3] * b[2] + a[2] * b[3] + a[1] * b[0] - a[0] * b[1]) >>> 16;
        r[3] = (a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2]) >>> 16;
      end
      OpScale: for (int i = 0; i < 4; i++) r[i] = (a[i] * s) >>> 16;
      OpDiv: begin
        if (s <= e) begin
          deg = 1'b1;
          for (int i = 0; i < 4; i++) r[i] = a[i];
        end else begin
          for (int i = 0; i < 4; i++) r[i] = (a[i] <<< 16) / s;
        end
      end
      OpConj: begin
        r[0] = -a[0]; r[1] = -a[1]; r[2] = -a[2]; r[3] = a[3];
      end
      OpInv: begin
        n2 = sq >>> 16;
        if (n2 <= e) begin
          deg = 1'b1;
          for (int i = 0; i < 4; i++) r[i] = a[i];
        end else begin
          for (int i = 0; i < 3; i++) r[i] = ((-a[i]) <<< 16) / n2;
          r[3] = (a[3] <<< 16) / n2;
        end
      end
      OpNorm: begin
        m = $signed({32'd0, isqrt64(sq64)});
        if (m <= e) begin
          deg = 1'b1;
          m = 96'sd65536;
        end
        for (int i = 0; i < 4; i++) r[i] = (a[i] <<< 16) / m;
      end
      OpLen:   mo = $signed({32'd0, isqrt64(sq64)});
      OpSqLen: mo = sq >>> 16;
      default: ;
    endcase
    if (mo > 96'sd2147483647) begin
      mo = 96'sd2147483647;
      sat = 1'b1;
    end
    // clip every lane to 32 bits
    for (int i = 0; i < 4; i++) begin
      if (r[i] > 96'sd2147483647) begin
        r[i] = 96'sd2147483647;
        sat = 1'b1;
      end else if (r[i] < -96'sd2147483648) begin
        r[i] = -96'sd2147483648;
        sat = 1'b1;
      end
    end
    o.r_x = r[0][31:0];
    o.r_y = r[1][31:0];
    o.r_z = r[2][31:0];
    o.r_w = r[3][31:0];
    o.magnitude = mo[30:0];
    o.saturated = sat;
    o.degenerate = deg;
    return o;
  endfunction

  // Driver: offers pending items, records expectations on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_rsp.push_back(quat_predict(in_data_i, eps_copy));
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          send_wait = no_idle ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver: checks each result, draws its own stalls
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          $error("result item with no expectation pending");
          n_errors++;
        end else begin
          exp_r = expected_rsp.pop_front();
          if (out_data_o.r_x !== exp_r.r_x) begin
            $error("r_x exp %h got %h", exp_r.r_x, out_data_o.r_x); n_errors++;
          end
          if (out_data_o.r_y !== exp_r.r_y) begin
            $error("r_y exp %h got %h", exp_r.r_y, out_data_o.r_y); n_errors++;
          end
          if (out_data_o.r_z !== exp_r.r_z) begin
            $error("r_z exp %h got %h", exp_r.r_z, out_data_o.r_z); n_errors++;
          end
          if (out_data_o.r_w !== exp_r.r_w) begin
            $error("r_w exp %h got %h", exp_r.r_w, out_data_o.r_w); n_errors++;
          end
          if (out_data_o.magnitude !== exp_r.magnitude) begin
            $error("magnitude exp %h got %h", exp_r.magnitude, out_data_o.magnitude);
            n_errors++;
          end
          if (out_data_o.saturated !== exp_r.saturated) begin
            $error("saturated exp %b got %b", exp_r.saturated, out_data_o.saturated);
            n_errors++;
          end
          if (out_data_o.degenerate !== exp_r.degenerate) begin
            $error("degenerate exp %b got %b", exp_r.degenerate, out_data_o.degenerate);
            n_errors++;
          end
        end
        n_results++;
        recv_wait = no_idle ? 0 : $urandom_range(0, 4);
        // one long hold so the pipeline backs up into the input
        if (n_results == 300) recv_wait = LongHold;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ready_i <= (recv_wait == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic apb_write_eps(logic [15:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {RegEps, 2'b00}; pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    eps_copy = v;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_rsp.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic req_t mk_item(logic [3:0] op, logic signed [31:0] ax, ay, az, aw,
                                   logic signed [31:0] bx, by, bz, bw, sc);
    req_t q;
    q.req_type = op;
    q.a_x = ax; q.a_y = ay; q.a_z = az; q.a_w = aw;
    q.b_x = bx; q.b_y = by; q.b_z = bz; q.b_w = bw;
    q.scalar_val = sc;
    return q;
  endfunction

  // Operand value: full range, moderate, extremes or tiny
  function automatic logic signed [31:0] rnd_val();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: case ($urandom_range(0, 4))
        0: v = QMax;
        1: v = QMin;
        2: v = QOne;
        3: v = -QOne;
        default: v = '0;
      endcase
      default: v = $signed($urandom_range(0, 8)) - 32'sd2;
    endcase
    return v;
  endfunction

  task automatic push_random(int unsigned n);
    req_t q;
    repeat (n) begin
      q = mk_item(4'($urandom_range(0, 15)), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
                  rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val());
      // divisors around the threshold
      if ($urandom_range(0, 3) == 0) q.scalar_val = $signed({16'd0, eps_copy})
                                         + $signed($urandom_range(0, 4)) - 32'sd2;
      pending_items.push_back(q);
    end
  endtask

  // Stimulus sequence
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    eps_copy = EpsReset;
    no_idle = 1'b0;
    send_wait = 0; recv_wait = 0; n_results = 0; n_cycles = 0; n_errors = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and special cases at the reset threshold
    pending_items.push_back(mk_item(OpAdd, QMax, QMin, QOne, 0, QMax, QMin, -QOne, 0, 0));
    pending_items.push_back(mk_item(OpSub, QMin, QMax, 5, -5, QMax, QMin, 5, 5, 0));
    pending_items.push_back(mk_item(OpMul, QMax, QMin, QMax, QMin, QMin, QMin, QMax, QMax, 0));
    pending_items.push_back(mk_item(OpMul, QOne, 2 * QOne, -QOne, QOne, QOne, -QOne, 3, QOne, 0));
    pending_items.push_back(mk_item(OpScale, QMax, QMin, -7, QOne, 0, 0, 0, 0, QMin));
    pending_items.push_back(mk_item(OpScale, 3, -3, QOne, -QOne, 0, 0, 0, 0, 32'sh0000_8000));
    pending_items.push_back(mk_item(OpDiv, QOne, -QOne, QMax, QMin, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpDiv, QOne, -QOne, QMax, QMin, 0, 0, 0, 0, -QOne));
    pending_items.push_back(mk_item(OpDiv, QOne, 2, 3, 4, 0, 0, 0, 0, 1));
    pending_items.push_back(mk_item(OpDiv, QMax, QMin, 7, -7, 0, 0, 0, 0, 2));
    pending_items.push_back(mk_item(OpDiv, QMax, QMin, 7, -7, 0, 0, 0, 0, QMax));
    pending_items.push_back(mk_item(OpConj, QMin, QMax, 0, QMin, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpInv, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpInv, 0, 0, 0, 300, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpInv, QOne, 0, -QOne, QOne, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpNorm, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpNorm, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpNorm, 3 * QOne, 4 * QOne, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpNorm, QMin, QMin, QMin, QMin, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpLen, QMin, QMin, QMin, QMin, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpLen, QMax, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpSqLen, QMax, QMin, QMax, QMin, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpSqLen, QOne, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpSpareLo, QMax, QMin, 1, 2, 3, 4, 5, 6, 7));
    pending_items.push_back(mk_item(OpSpareHi, QMax, QMin, 1, 2, 3, 4, 5, 6, 7));
    wait_idle();

    // zero threshold, random with idling (includes the long hold)
    apb_write_eps(16'd0);
    pending_items.push_back(mk_item(OpDiv, QOne, 1, 2, 3, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(OpInv, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    push_random(450);
    wait_idle();

    // highest threshold, no idling on either side
    apb_write_eps(16'hFFFF);
    no_idle = 1'b1;
    push_random(200);
    wait_idle();

    // random threshold, idling again
    no_idle = 1'b0;
    apb_write_eps(16'($urandom));
    push_random(250);
    wait_idle();

    // back to a threshold of one
    apb_write_eps(EpsReset);
    push_random(200);
    wait_idle();

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/qalu_pkg.sv
sv/qalu_front.sv
sv/qalu_sqrt.sv
sv/qalu_div.sv
sv/quaternion_alu_top.sv
tb/tb_quaternion_alu_top.sv
